>>> design/cmgl_pkg.sv
`timescale 1ns / 1ps
package cmgl_pkg;

  // table sizes
  localparam int MAX_SEGMENTS = 64;
  localparam int GLYPH_WORDS  = 1024;

  // end codes are searched this many segments per memory row
  localparam int LANES  = 8;
  localparam int LANE_W = $clog2(LANES);
  localparam int ROWS   = (MAX_SEGMENTS + LANES - 1) / LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam int SLOT_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int GLYPH_AW = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;

  // signed glyph array position: 16-bit offset plus halved range offset less count
  localparam int POS_W = 18;

  localparam int WORD_W = 16;
  localparam int CFG_W  = 7;
  localparam int CFG_AW = 3;
  localparam int APB_DW = 32;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    OP_WRITE_SEG   = 2'd0,
    OP_WRITE_GLYPH = 2'd1,
    OP_LOOKUP      = 2'd2,
    OP_UNUSED      = 2'd3
  } op_t;

  // register indexes
  localparam logic REG_SEGMENTS_IN_USE = 1'b0;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    word_t             end_code;
    word_t             start_code;
    word_t             delta;
    word_t             range_offset;
  } seg_wr_t;

  typedef struct packed {
    word_t start_code;
    word_t delta;
    word_t range_offset;
  } seg_rec_t;

  localparam int REC_W = $bits(seg_rec_t);

  typedef logic [LANES-1:0][WORD_W-1:0] end_row_t;

  typedef struct packed {
    logic                en;
    logic [GLYPH_AW-1:0] addr;
    word_t               data;
  } glyph_wr_t;

endpackage

>>> design/cmgl_ram.sv
`timescale 1ns / 1ps
module cmgl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/cmgl_cfg.sv
`timescale 1ns / 1ps
module cmgl_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [cmgl_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [cmgl_pkg::APB_DW-1:0]      cfg_pwdata,
  output logic [cmgl_pkg::APB_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready,
  output logic [cmgl_pkg::CFG_W-1:0]       segments_in_use
);

  logic [cmgl_pkg::CFG_W-1:0] seg_cnt_r;
  logic [cmgl_pkg::CFG_W-1:0] seg_cnt_nxt;
  logic                       reg_sel;

  // register index from the word address
  assign reg_sel = (cfg_paddr[2] == cmgl_pkg::REG_SEGMENTS_IN_USE);

  always_comb begin
    seg_cnt_nxt = seg_cnt_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      seg_cnt_nxt = cfg_pwdata[cmgl_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r <= cmgl_pkg::CFG_W'(1);
    end else begin
      seg_cnt_r <= seg_cnt_nxt;
    end
  end

  // read back
  assign cfg_prdata = reg_sel ? cmgl_pkg::APB_DW'(seg_cnt_r) : '0;
  assign cfg_pready = 1'b1;
  assign segments_in_use = seg_cnt_r;

endmodule

>>> design/cmgl_seg_store.sv
`timescale 1ns / 1ps
module cmgl_seg_store (
  input  logic                           clk,
  input  cmgl_pkg::seg_wr_t              seg_wr,
  input  logic [cmgl_pkg::ROW_W-1:0]     end_rd_row,
  input  logic [cmgl_pkg::SLOT_W-1:0]    rec_rd_slot,
  output cmgl_pkg::end_row_t             end_row,
  output cmgl_pkg::seg_rec_t             rec
);

  localparam int SX_W = cmgl_pkg::SLOT_W + cmgl_pkg::LANE_W;

  logic [SX_W-1:0]                 slot_x;
  logic [cmgl_pkg::LANE_W-1:0]     wr_lane;
  logic [cmgl_pkg::ROW_W-1:0]      wr_row;
  cmgl_pkg::seg_rec_t              wr_rec;
  logic [cmgl_pkg::REC_W-1:0]      rec_bits;

  // segment number splits into lane (bank) and row
  assign slot_x  = SX_W'(seg_wr.slot);
  assign wr_lane = slot_x[cmgl_pkg::LANE_W-1:0];
  assign wr_row  = cmgl_pkg::ROW_W'(slot_x >> cmgl_pkg::LANE_W);

  // end codes: one bank per lane, a row read gives all lanes at once
  for (genvar i = 0; i < cmgl_pkg::LANES; i++) begin : g_end_bank
    cmgl_ram #(
      .WIDTH(cmgl_pkg::WORD_W),
      .DEPTH(cmgl_pkg::ROWS)
    ) u_end_ram (
      .clk  (clk),
      .we   (seg_wr.en && (wr_lane == cmgl_pkg::LANE_W'(i))),
      .waddr(wr_row),
      .wdata(seg_wr.end_code),
      .raddr(end_rd_row),
      .rdata(end_row[i])
    );
  end

  // start, delta and range offset per segment
  assign wr_rec.start_code   = seg_wr.start_code;
  assign wr_rec.delta        = seg_wr.delta;
  assign wr_rec.range_offset = seg_wr.range_offset;

  cmgl_ram #(
    .WIDTH(cmgl_pkg::REC_W),
    .DEPTH(cmgl_pkg::MAX_SEGMENTS)
  ) u_rec_ram (
    .clk  (clk),
    .we   (seg_wr.en),
    .waddr(seg_wr.slot),
    .wdata(wr_rec),
    .raddr(rec_rd_slot),
    .rdata(rec_bits)
  );

  assign rec = cmgl_pkg::seg_rec_t'(rec_bits);

endmodule

>>> design/cmgl_engine.sv
`timescale 1ns / 1ps
module cmgl_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_opcode,
  input  logic [5:0]                      in_seg_slot,
  input  logic [15:0]                     in_seg_end,
  input  logic [15:0]                     in_seg_start,
  input  logic [15:0]                     in_seg_delta,
  input  logic [15:0]                     in_seg_range_offset,
  input  logic [9:0]                      in_glyph_addr,
  input  logic [15:0]                     in_glyph_word,
  input  logic [15:0]                     in_char_code,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [15:0]                     out_glyph_index,
  output logic                            out_in_segment,
  output logic                            out_array_error,
  input  logic [cmgl_pkg::CFG_W-1:0]      segments_in_use,
  output cmgl_pkg::seg_wr_t               seg_wr,
  output logic [cmgl_pkg::ROW_W-1:0]      end_rd_row,
  output logic [cmgl_pkg::SLOT_W-1:0]     rec_rd_slot,
  input  cmgl_pkg::end_row_t              end_row,
  input  cmgl_pkg::seg_rec_t              rec,
  output cmgl_pkg::glyph_wr_t             glyph_wr,
  output logic [cmgl_pkg::GLYPH_AW-1:0]   glyph_rd_addr,
  input  cmgl_pkg::word_t                 glyph_rdata
);

  localparam int IDX_W = cmgl_pkg::ROW_W + cmgl_pkg::LANE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REC,
    S_CHK,
    S_GLY,
    S_FIN
  } state_t;

  state_t                          state_r, state_nxt;
  cmgl_pkg::word_t                 code_r, code_nxt;
  logic [cmgl_pkg::CNT_W-1:0]      n_r, n_nxt;
  logic [cmgl_pkg::ROW_W-1:0]      last_row_r, last_row_nxt;
  logic [cmgl_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [cmgl_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic [cmgl_pkg::POS_W-1:0]      pos_r, pos_nxt;
  cmgl_pkg::word_t                 res_glyph_r, res_glyph_nxt;
  logic                            res_in_r, res_in_nxt;
  logic                            res_err_r, res_err_nxt;
  logic                            out_valid_r, out_valid_nxt;
  cmgl_pkg::word_t                 out_glyph_r, out_glyph_nxt;
  logic                            out_in_r, out_in_nxt;
  logic                            out_err_r, out_err_nxt;

  logic                            accept;
  logic [cmgl_pkg::CNT_W-1:0]      n_sat;
  logic [cmgl_pkg::LANES-1:0]      lane_hit;
  logic                            hit_any;
  logic [cmgl_pkg::LANE_W-1:0]     hit_lane;
  logic [IDX_W-1:0]                hit_idx;
  logic [cmgl_pkg::SLOT_W-1:0]     hit_slot;
  logic [cmgl_pkg::CNT_W-1:0]      slots_left;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // segment count saturates at the table size
  assign n_sat = (32'(segments_in_use) > cmgl_pkg::MAX_SEGMENTS)
               ? cmgl_pkg::CNT_W'(cmgl_pkg::MAX_SEGMENTS)
               : cmgl_pkg::CNT_W'(segments_in_use);

  // table writes go straight to memory on the request edge
  always_comb begin
    seg_wr.en           = accept && (in_opcode == cmgl_pkg::OP_WRITE_SEG)
                          && (32'(in_seg_slot) < cmgl_pkg::MAX_SEGMENTS);
    seg_wr.slot         = cmgl_pkg::SLOT_W'(in_seg_slot);
    seg_wr.end_code     = in_seg_end;
    seg_wr.start_code   = in_seg_start;
    seg_wr.delta        = in_seg_delta;
    seg_wr.range_offset = in_seg_range_offset;
    glyph_wr.en         = accept && (in_opcode == cmgl_pkg::OP_WRITE_GLYPH)
                          && (32'(in_glyph_addr) < cmgl_pkg::GLYPH_WORDS);
    glyph_wr.addr       = cmgl_pkg::GLYPH_AW'(in_glyph_addr);
    glyph_wr.data       = in_glyph_word;
  end

  // compare one row of end codes against the code, first lane wins
  always_comb begin
    logic [IDX_W-1:0] idx;
    lane_hit = '0;
    hit_lane = '0;
    for (int i = 0; i < cmgl_pkg::LANES; i++) begin
      idx = {row_r, cmgl_pkg::LANE_W'(i)};
      lane_hit[i] = (32'(idx) < 32'(n_r)) && (end_row[i] >= code_r);
    end
    for (int i = cmgl_pkg::LANES - 1; i >= 0; i--) begin
      if (lane_hit[i]) begin
        hit_lane = cmgl_pkg::LANE_W'(i);
      end
    end
  end

  assign hit_any  = |lane_hit;
  assign hit_idx  = {row_r, hit_lane};
  assign hit_slot = cmgl_pkg::SLOT_W'(hit_idx);
  assign slots_left = n_r - cmgl_pkg::CNT_W'(slot_r);

  // memory read addresses
  assign end_rd_row    = (state_r == S_IDLE) ? '0 : row_r + 1'b1;
  assign rec_rd_slot   = (state_r == S_SCAN) ? hit_slot : slot_r;
  assign glyph_rd_addr = pos_r[cmgl_pkg::GLYPH_AW-1:0];

  // lookup sequencer
  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    n_nxt         = n_r;
    last_row_nxt  = last_row_r;
    row_nxt       = row_r;
    slot_nxt      = slot_r;
    pos_nxt       = pos_r;
    res_glyph_nxt = res_glyph_r;
    res_in_nxt    = res_in_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_glyph_nxt = out_glyph_r;
    out_in_nxt    = out_in_r;
    out_err_nxt   = out_err_r;

    case (state_r)
      S_IDLE: begin
        if (accept && (in_opcode == cmgl_pkg::OP_LOOKUP)) begin
          code_nxt      = in_char_code;
          n_nxt         = n_sat;
          last_row_nxt  = cmgl_pkg::ROW_W'((n_sat - 1'b1) >> cmgl_pkg::LANE_W);
          row_nxt       = '0;
          res_glyph_nxt = '0;
          res_in_nxt    = 1'b0;
          res_err_nxt   = 1'b0;
          state_nxt     = (n_sat == '0) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit_any) begin
          slot_nxt  = hit_slot;
          state_nxt = S_REC;
        end else if (row_r == last_row_r) begin
          state_nxt = S_FIN;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      S_REC: begin
        if (code_r >= rec.start_code) begin
          res_in_nxt = 1'b1;
          if (rec.range_offset == '0) begin
            res_glyph_nxt = code_r + rec.delta;
            state_nxt     = S_FIN;
          end else begin
            pos_nxt = cmgl_pkg::POS_W'(code_r - rec.start_code)
                    + cmgl_pkg::POS_W'(rec.range_offset >> 1)
                    - cmgl_pkg::POS_W'(slots_left);
            state_nxt = S_CHK;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CHK: begin
        // negative or past the end of the glyph array
        if (pos_r[cmgl_pkg::POS_W-1]
            || (pos_r >= cmgl_pkg::POS_W'(cmgl_pkg::GLYPH_WORDS))) begin
          res_err_nxt = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          state_nxt = S_GLY;
        end
      end
      S_GLY: begin
        res_glyph_nxt = (glyph_rdata == '0) ? '0 : glyph_rdata + rec.delta;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_glyph_nxt = res_glyph_r;
          out_in_nxt    = res_in_r;
          out_err_nxt   = res_err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    code_r      <= code_nxt;
    n_r         <= n_nxt;
    last_row_r  <= last_row_nxt;
    row_r       <= row_nxt;
    slot_r      <= slot_nxt;
    pos_r       <= pos_nxt;
    res_glyph_r <= res_glyph_nxt;
    res_in_r    <= res_in_nxt;
    res_err_r   <= res_err_nxt;
    out_glyph_r <= out_glyph_nxt;
    out_in_r    <= out_in_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_glyph_index = out_glyph_r;
  assign out_in_segment  = out_in_r;
  assign out_array_error = out_err_r;

  // scan never runs past the last populated row
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (row_r <= last_row_r))
    else $error("segment scan passed last row");

  // a lookup holds off further requests until it is done
  a_lookup_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == cmgl_pkg::OP_LOOKUP)) |=> !in_ready)
    else $error("request taken during lookup");

  // table writes finish on the request edge
  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode != cmgl_pkg::OP_LOOKUP)) |=> in_ready)
    else $error("write request stalled the engine");

  // an array fault always comes from inside a segment with glyph zero
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_in_r && (out_glyph_r == '0)))
    else $error("array error with bad result fields");

  // a miss gives glyph zero and no fault
  a_miss_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_in_r) |-> ((out_glyph_r == '0) && !out_err_r))
    else $error("miss with nonzero result fields");

endmodule

>>> design/cmap_segment_glyph_lookup_core.sv
`timescale 1ns / 1ps
// channel   | handshake                          | payload
// in_       | in_valid / in_ready                | opcode, segment fields, glyph word, code
// out_      | out_valid / out_ready              | glyph_index, in_segment, array_error
// cfg_      | apb write at psel&penable&pwrite   | segments_in_use at byte address 0
//
// writes leave the input ready; a lookup scans one row of eight end codes per cycle,
// up to ceil(n/8) rows, then up to the record, range check, glyph read and result
// steps; out_valid rises as the result step ends, with input ready on that edge
// synchronous active-low reset clears control only; tables hold garbage until written
// a finished result waits in the output register while new requests are taken, and
// a second lookup stalls only at its own result
module cmap_segment_glyph_lookup_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_opcode,
  input  logic [5:0]                  in_seg_slot,
  input  logic [15:0]                 in_seg_end,
  input  logic [15:0]                 in_seg_start,
  input  logic [15:0]                 in_seg_delta,
  input  logic [15:0]                 in_seg_range_offset,
  input  logic [9:0]                  in_glyph_addr,
  input  logic [15:0]                 in_glyph_word,
  input  logic [15:0]                 in_char_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 out_glyph_index,
  output logic                        out_in_segment,
  output logic                        out_array_error,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cmgl_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [cmgl_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [cmgl_pkg::APB_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  logic [cmgl_pkg::CFG_W-1:0]     segments_in_use;
  cmgl_pkg::seg_wr_t              seg_wr;
  logic [cmgl_pkg::ROW_W-1:0]     end_rd_row;
  logic [cmgl_pkg::SLOT_W-1:0]    rec_rd_slot;
  cmgl_pkg::end_row_t             end_row;
  cmgl_pkg::seg_rec_t             rec;
  cmgl_pkg::glyph_wr_t            glyph_wr;
  logic [cmgl_pkg::GLYPH_AW-1:0]  glyph_rd_addr;
  cmgl_pkg::word_t                glyph_rdata;

  // configuration register
  cmgl_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .segments_in_use(segments_in_use)
  );

  // segment table
  cmgl_seg_store u_seg_store (
    .clk        (clk),
    .seg_wr     (seg_wr),
    .end_rd_row (end_rd_row),
    .rec_rd_slot(rec_rd_slot),
    .end_row    (end_row),
    .rec        (rec)
  );

  // glyph id array
  cmgl_ram #(
    .WIDTH(cmgl_pkg::WORD_W),
    .DEPTH(cmgl_pkg::GLYPH_WORDS)
  ) u_glyph_ram (
    .clk  (clk),
    .we   (glyph_wr.en),
    .waddr(glyph_wr.addr),
    .wdata(glyph_wr.data),
    .raddr(glyph_rd_addr),
    .rdata(glyph_rdata)
  );

  // request handling and lookup sequencing
  cmgl_engine u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_seg_slot        (in_seg_slot),
    .in_seg_end         (in_seg_end),
    .in_seg_start       (in_seg_start),
    .in_seg_delta       (in_seg_delta),
    .in_seg_range_offset(in_seg_range_offset),
    .in_glyph_addr      (in_glyph_addr),
    .in_glyph_word      (in_glyph_word),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_glyph_index    (out_glyph_index),
    .out_in_segment     (out_in_segment),
    .out_array_error    (out_array_error),
    .segments_in_use    (segments_in_use),
    .seg_wr             (seg_wr),
    .end_rd_row         (end_rd_row),
    .rec_rd_slot        (rec_rd_slot),
    .end_row            (end_row),
    .rec                (rec),
    .glyph_wr           (glyph_wr),
    .glyph_rd_addr      (glyph_rd_addr),
    .glyph_rdata        (glyph_rdata)
  );

endmodule
